[rtl/core/motor_start_stop_sequencer_top_macros.svh]
// Assertion helpers shared by the checker
`ifndef MOTOR_START_STOP_SEQUENCER_TOP_MACROS_SVH
`define MOTOR_START_STOP_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define MSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/mss_pkg.sv]
`default_nettype none
package mss_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int SLOT_COUNT  = 2 * MOTOR_COUNT;
  localparam int ADDR_W      = 7;
  localparam int SPEED_W     = 8;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [7:0] REG_ENABLE  = 8'hA0;
  localparam logic [7:0] REG_DISABLE = 8'hA1;
  localparam logic [7:0] REG_SPEED   = 8'hA2;

  localparam logic [7:0]  RST_START_FLOOR     = 8'd45;
  localparam logic [7:0]  RST_LEVEL_FIRST     = 8'd30;
  localparam logic [7:0]  RST_LEVEL_LIMIT     = 8'd50;
  localparam logic [7:0]  RST_JITTER          = 8'd25;
  localparam logic [3:0]  RST_MOTOR_MASK      = 4'hF;
  localparam logic [27:0] RST_MOTOR_ADDRESSES = 28'd219870569;
  localparam logic [15:0] RST_SETTLE_TICKS    = 16'd340;

  typedef enum logic [2:0] {
    CFG_START_FLOOR     = 3'd0,
    CFG_LEVEL_FIRST     = 3'd1,
    CFG_LEVEL_LIMIT     = 3'd2,
    CFG_JITTER          = 3'd3,
    CFG_MOTOR_MASK      = 3'd4,
    CFG_MOTOR_ADDRESSES = 3'd5,
    CFG_SETTLE_TICKS    = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  start_floor;
    logic [7:0]  level_first;
    logic [7:0]  level_limit;
    logic [7:0]  jitter;
    logic [3:0]  motor_mask;
    logic [27:0] motor_addresses;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_ALL_SPEEDS,
    JOB_ENABLE,
    JOB_RAMP,
    JOB_STOP
  } job_kind_t;

  typedef struct packed {
    job_kind_t                               kind;
    logic [SLOT_COUNT-1:0]                   slots;
    logic [MOTOR_COUNT-1:0][SPEED_W-1:0]     speed;
    logic [SPEED_W-1:0]                      value;
    logic                                    running;
  } job_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [27:0] addrs,
                                                input logic [1:0] motor);
    logic [ADDR_W-1:0] a;
    a = '0;
    unique case (motor)
      2'd0: a = addrs[6:0];
      2'd1: a = addrs[13:7];
      2'd2: a = addrs[20:14];
      2'd3: a = addrs[27:21];
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/core/mss_cfg.sv]
`default_nettype none
module mss_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mss_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mss_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mss_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output mss_pkg::cfg_t                     cfg
);
  import mss_pkg::*;

  cfg_index_t idx;
  logic       wr;

  assign idx    = cfg_index_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_floor     <= RST_START_FLOOR;
      cfg.level_first     <= RST_LEVEL_FIRST;
      cfg.level_limit     <= RST_LEVEL_LIMIT;
      cfg.jitter          <= RST_JITTER;
      cfg.motor_mask      <= RST_MOTOR_MASK;
      cfg.motor_addresses <= RST_MOTOR_ADDRESSES;
      cfg.settle_ticks    <= RST_SETTLE_TICKS;
    end else if (wr) begin
      unique case (idx)
        CFG_START_FLOOR:     cfg.start_floor     <= pwdata[7:0];
        CFG_LEVEL_FIRST:     cfg.level_first     <= pwdata[7:0];
        CFG_LEVEL_LIMIT:     cfg.level_limit     <= pwdata[7:0];
        CFG_JITTER:          cfg.jitter          <= pwdata[7:0];
        CFG_MOTOR_MASK:      cfg.motor_mask      <= pwdata[3:0];
        CFG_MOTOR_ADDRESSES: cfg.motor_addresses <= pwdata[27:0];
        CFG_SETTLE_TICKS:    cfg.settle_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      CFG_START_FLOOR:     prdata = {24'd0, cfg.start_floor};
      CFG_LEVEL_FIRST:     prdata = {24'd0, cfg.level_first};
      CFG_LEVEL_LIMIT:     prdata = {24'd0, cfg.level_limit};
      CFG_JITTER:          prdata = {24'd0, cfg.jitter};
      CFG_MOTOR_MASK:      prdata = {28'd0, cfg.motor_mask};
      CFG_MOTOR_ADDRESSES: prdata = {4'd0, cfg.motor_addresses};
      CFG_SETTLE_TICKS:    prdata = {16'd0, cfg.settle_ticks};
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/mss_front.sv]
`default_nettype none
module mss_front (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  mss_pkg::cfg_t                                     cfg,
  input  wire logic                                         in_valid,
  output logic                                              in_stall,
  input  wire logic                                         action,
  input  wire logic [mss_pkg::MOTOR_COUNT-1:0][mss_pkg::SPEED_W-1:0] speed,
  input  wire logic                                         q_full,
  output logic                                              q_push,
  output mss_pkg::job_t                                     q_job
);
  import mss_pkg::*;

  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_SETTLING = 2'd1,
    MODE_RAMPING  = 2'd2,
    MODE_RUNNING  = 2'd3
  } mode_t;

  mode_t       mode, mode_next, br_mode;
  logic [15:0] settle_count, settle_count_next, settle_dec;
  logic [7:0]  ramp_level, ramp_level_next, br_level, level_inc;
  logic [8:0]  step_count, step_count_next, step_inc;
  logic [2:0]  step_mod_seven, step_mod_seven_next, mod_inc;
  logic        accept, all_above, any_zero;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign br_level   = (cfg.level_first == 8'd0) ? 8'd1 : cfg.level_first;
  assign br_mode    = (br_level < cfg.level_limit) ? MODE_RAMPING : MODE_RUNNING;
  assign settle_dec = (settle_count != 16'd0) ? settle_count - 16'd1 : 16'd0;
  assign step_inc   = step_count + 9'd1;
  assign mod_inc    = (step_mod_seven >= 3'd6) ? 3'd0 : step_mod_seven + 3'd1;
  assign level_inc  = ramp_level + 8'd1;

  always_comb begin
    all_above = 1'b1;
    any_zero  = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (speed[i] <= cfg.start_floor) all_above = 1'b0;
      if (speed[i] == 8'd0) any_zero = 1'b1;
    end
  end

  always_comb begin
    mode_next           = mode;
    settle_count_next   = settle_count;
    ramp_level_next     = ramp_level;
    step_count_next     = step_count;
    step_mod_seven_next = step_mod_seven;
    q_job.kind          = JOB_ALL_SPEEDS;
    q_job.slots         = '0;
    q_job.speed         = speed;
    q_job.value         = '0;
    if (!action) begin
      priority if (mode == MODE_STOPPED) begin
        if (all_above) begin
          q_job.kind        = JOB_ENABLE;
          q_job.slots       = {4'd0, cfg.motor_mask};
          settle_count_next = cfg.settle_ticks;
          mode_next         = MODE_SETTLING;
          if (cfg.settle_ticks == 16'd0) begin
            ramp_level_next     = br_level;
            step_count_next     = '0;
            step_mod_seven_next = '0;
            mode_next           = br_mode;
          end
        end else begin
          q_job.slots = {4'd0, 4'hF};
        end
      end else if (mode == MODE_RUNNING) begin
        if (any_zero) begin
          q_job.kind  = JOB_STOP;
          q_job.slots = {cfg.motor_mask, cfg.motor_mask};
          mode_next   = MODE_STOPPED;
        end else begin
          q_job.slots = {4'd0, 4'hF};
        end
      end else begin
        q_job.slots = '0;
      end
    end else begin
      priority if (mode == MODE_SETTLING) begin
        settle_count_next = settle_dec;
        if (settle_dec == 16'd0) begin
          ramp_level_next     = br_level;
          step_count_next     = '0;
          step_mod_seven_next = '0;
          mode_next           = br_mode;
        end
      end else if (mode == MODE_RAMPING) begin
        q_job.kind  = JOB_RAMP;
        q_job.slots = {4'd0, cfg.motor_mask};
        q_job.value = (step_mod_seven == 3'd0) ? ramp_level - cfg.jitter
                                               : ramp_level + cfg.jitter;
        step_count_next     = step_inc;
        step_mod_seven_next = mod_inc;
        if (step_inc >= {ramp_level, 1'b0}) begin
          step_count_next     = '0;
          step_mod_seven_next = '0;
          ramp_level_next     = level_inc;
          if (level_inc == 8'd0 || level_inc >= cfg.level_limit) mode_next = MODE_RUNNING;
        end
      end else begin
        q_job.slots = '0;
      end
    end
    q_job.running = (mode_next == MODE_RUNNING);
  end

  assign q_push = accept && (q_job.slots != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_STOPPED;
      settle_count   <= '0;
      ramp_level     <= '0;
      step_count     <= '0;
      step_mod_seven <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      settle_count   <= settle_count_next;
      ramp_level     <= ramp_level_next;
      step_count     <= step_count_next;
      step_mod_seven <= step_mod_seven_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mss_queue.sv]
`default_nettype none
module mss_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  mss_pkg::job_t push_job,
  output logic         full,
  input  wire logic    pop,
  output logic         empty,
  output mss_pkg::job_t head
);
  import mss_pkg::*;

  job_t       entry [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/mss_back.sv]
`default_nettype none
module mss_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  mss_pkg::cfg_t                    cfg,
  input  wire logic                        q_empty,
  input  mss_pkg::job_t                    q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mss_pkg::ADDR_W-1:0]       bus_address,
  output logic [7:0]                       device_register,
  output logic [mss_pkg::SPEED_W-1:0]      write_data,
  output logic                             last_write,
  output logic                             motors_running
);
  import mss_pkg::*;

  job_t                  cur;
  logic [SLOT_COUNT-1:0] pending, pick, rest;
  logic [2:0]            slot;
  logic [1:0]            motor, target;
  logic                  adv, is_disable;
  logic [ADDR_W-1:0]     addr_n;
  logic [7:0]            reg_n, data_n;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = (pending == '0) && !q_empty;
  assign pick  = pending & (~pending + SLOT_COUNT'(1));
  assign rest  = pending & ~pick;

  always_comb begin
    slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (pick[i]) slot = 3'(i);
    end
  end

  assign is_disable = slot[2];
  assign motor      = slot[1:0];
  assign target     = (cur.kind == JOB_STOP && !is_disable) ? motor + 2'd3 : motor;

  always_comb begin
    addr_n = addr_of(cfg.motor_addresses, target);
    reg_n  = REG_SPEED;
    data_n = '0;
    if (is_disable) begin
      reg_n = REG_DISABLE;
    end else begin
      unique case (cur.kind)
        JOB_ALL_SPEEDS: data_n = cur.speed[target];
        JOB_ENABLE:     reg_n  = REG_ENABLE;
        JOB_RAMP:       data_n = cur.value;
        JOB_STOP:       data_n = cur.speed[target];
        default:        data_n = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= (pending != '0);
      priority if (pending == '0) begin
        if (!q_empty) pending <= q_head.slots;
      end else if (adv) begin
        pending <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (adv && pending != '0) begin
      bus_address     <= addr_n;
      device_register <= reg_n;
      write_data      <= data_n;
      last_write      <= (rest == '0);
      motors_running  <= cur.running;
    end
  end

endmodule
`default_nettype wire

[rtl/core/motor_start_stop_sequencer_top.sv]
// Motor start/stop sequencer for four controllers on a shared register bus.
// Input channel (in_valid/in_stall): action 0 is a speed update carrying
// speed_0..speed_3, action 1 is a pacing tick. Output channel
// (out_valid/out_stall): one bus register write per transaction, with
// last_write marking the final write caused by an input and motors_running
// the mode after that input. Registers sit on the APB port at 4*index.
// The write expander issues one write per cycle while the receiver does not
// stall. It loads each input's write list from the queue before issuing its
// writes, and an input causes up to eight writes. Inputs that cause no
// writes never enter the queue. A two-entry queue between the decoder and
// the expander lets the input side keep accepting while writes drain.
// When the receiver stalls, the current write holds and the queue fills;
// in_stall rises when it is full. Reset restores register defaults, puts
// the sequencer in the stopped state and drops all pending writes.
`default_nettype none
module motor_start_stop_sequencer_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [7:0]                   speed_0,
  input  wire logic [7:0]                   speed_1,
  input  wire logic [7:0]                   speed_2,
  input  wire logic [7:0]                   speed_3,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [6:0]                        bus_address,
  output logic [7:0]                        device_register,
  output logic [7:0]                        write_data,
  output logic                              last_write,
  output logic                              motors_running,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mss_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mss_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mss_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import mss_pkg::*;

  cfg_t                                cfg;
  job_t                                push_job, head;
  logic                                push, pop, full, empty;
  logic [MOTOR_COUNT-1:0][SPEED_W-1:0] speed;

  assign speed = {speed_3, speed_2, speed_1, speed_0};

  mss_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  mss_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .speed(speed), .q_full(full), .q_push(push), .q_job(push_job)
  );

  mss_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  mss_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(empty), .q_head(head), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .bus_address(bus_address),
    .device_register(device_register), .write_data(write_data),
    .last_write(last_write), .motors_running(motors_running)
  );

endmodule
`default_nettype wire

[rtl/core/mss_checker.sv]
`default_nettype none
`include "motor_start_stop_sequencer_top_macros.svh"
module mss_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [6:0] bus_address,
  input wire logic [7:0] device_register,
  input wire logic [7:0] write_data,
  input wire logic       last_write,
  input wire logic       motors_running
);
  import mss_pkg::*;

  logic [24:0] payload;
  logic        ctl_reg, known_reg;

  assign payload   = {bus_address, device_register, write_data, last_write, motors_running};
  assign ctl_reg   = (device_register == REG_ENABLE) || (device_register == REG_DISABLE);
  assign known_reg = ctl_reg || (device_register == REG_SPEED);

  `MSS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(payload))
  `MSS_ASSERT_NOW(a_legal_reg, clk, rst, out_valid, known_reg)
  `MSS_ASSERT_NOW(a_ctl_zero, clk, rst, out_valid && ctl_reg, write_data == 8'd0)
  `MSS_ASSERT_NOW(a_disable_stops, clk, rst, out_valid && device_register == REG_DISABLE, !motors_running)

endmodule

bind motor_start_stop_sequencer_top mss_checker u_mss_checker (.*);
`default_nettype wire

[bench/motor_start_stop_sequencer_top_tb.sv]
`default_nettype none
module motor_start_stop_sequencer_top_tb;
  import mss_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 30;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 4;
  localparam int ITEMS_PER_PHASE = 34;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  typedef enum logic [1:0] {
    SEQ_STOPPED,
    SEQ_SETTLING,
    SEQ_RAMPING,
    SEQ_RUNNING
  } seq_mode_t;

  typedef struct packed {
    logic [6:0] bus_address;
    logic [7:0] device_register;
    logic [7:0] write_data;
    logic       last_write;
    logic       motors_running;
  } bus_write_t;

  typedef struct packed {
    logic [1:0] cfg_set;
    logic       act;
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] s3;
    logic       typed;
    logic [6:0] t_addr;
    logic [7:0] t_reg;
    logic [7:0] t_data;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic action = 1'b0;
  logic [7:0] speed_0 = 8'd0;
  logic [7:0] speed_1 = 8'd0;
  logic [7:0] speed_2 = 8'd0;
  logic [7:0] speed_3 = 8'd0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic in_stall;
  logic out_valid;
  logic [6:0] bus_address;
  logic [7:0] device_register;
  logic [7:0] write_data;
  logic last_write;
  logic motors_running;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  cfg_t       cfg_model;
  seq_mode_t  seq_mode;
  logic [15:0] settle_left;
  logic [7:0]  ramp_level;
  logic [8:0]  step_count;
  logic [2:0]  step_mod7;

  bus_write_t writes_due[$];
  dir_row_t   dir_steps[$];

  int err_count = 0;
  int items_in = 0;
  int writes_seen = 0;
  int starts = 0;
  int stops = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;

  motor_start_stop_sequencer_top u_top (.*);

  always #5 clk = ~clk;

  function automatic cfg_t settings(input logic [7:0] min_spd, input logic [7:0] r_start,
                                    input logic [7:0] r_end, input logic [7:0] jit,
                                    input logic [3:0] mask, input logic [27:0] addrs,
                                    input logic [15:0] settle);
    cfg_t c;
    c.start_floor     = min_spd;
    c.level_first     = r_start;
    c.level_limit     = r_end;
    c.jitter          = jit;
    c.motor_mask      = mask;
    c.motor_addresses = addrs;
    c.settle_ticks    = settle;
    return c;
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] set, input logic act,
                                       input logic [7:0] s0, input logic [7:0] s1,
                                       input logic [7:0] s2, input logic [7:0] s3,
                                       input logic typed, input logic [6:0] a,
                                       input logic [7:0] r, input logic [7:0] d);
    dir_row_t row;
    row.cfg_set = set;
    row.act     = act;
    row.s0      = s0;
    row.s1      = s1;
    row.s2      = s2;
    row.s3      = s3;
    row.typed   = typed;
    row.t_addr  = a;
    row.t_reg   = r;
    row.t_data  = d;
    return row;
  endfunction

  function automatic logic [6:0] motor_bus_addr(input int m);
    return cfg_model.motor_addresses[7*m +: 7];
  endfunction

  function automatic bus_write_t bus_write(input logic [6:0] a, input logic [7:0] r,
                                           input logic [7:0] d);
    bus_write_t w;
    w = '0;
    w.bus_address     = a;
    w.device_register = r;
    w.write_data      = d;
    return w;
  endfunction

  function automatic void enter_ramp();
    ramp_level = (cfg_model.level_first == 8'd0) ? 8'd1 : cfg_model.level_first;
    step_count = '0;
    step_mod7  = '0;
    seq_mode   = (ramp_level < cfg_model.level_limit) ? SEQ_RAMPING : SEQ_RUNNING;
  endfunction

  function automatic int predict_writes(input logic act, input logic [3:0][7:0] spd);
    bus_write_t w[$];
    logic all_above;
    logic any_zero;
    logic [7:0] level_out;
    all_above = 1'b1;
    any_zero  = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (spd[i] <= cfg_model.start_floor) all_above = 1'b0;
      if (spd[i] == 8'd0) any_zero = 1'b1;
    end
    if (act == ACT_UPDATE) begin
      if (seq_mode == SEQ_STOPPED && all_above) begin
        for (int i = 0; i < MOTOR_COUNT; i++)
          if (cfg_model.motor_mask[i]) w.push_back(bus_write(motor_bus_addr(i), REG_ENABLE, 8'd0));
        settle_left = cfg_model.settle_ticks;
        seq_mode = SEQ_SETTLING;
        starts++;
        if (settle_left == 16'd0) enter_ramp();
      end else if (seq_mode == SEQ_RUNNING && any_zero) begin
        for (int i = 0; i < MOTOR_COUNT; i++)
          if (cfg_model.motor_mask[i])
            w.push_back(bus_write(motor_bus_addr((i + 3) % 4), REG_SPEED, spd[(i + 3) % 4]));
        for (int i = 0; i < MOTOR_COUNT; i++)
          if (cfg_model.motor_mask[i]) w.push_back(bus_write(motor_bus_addr(i), REG_DISABLE, 8'd0));
        seq_mode = SEQ_STOPPED;
        stops++;
      end else if (seq_mode == SEQ_STOPPED || seq_mode == SEQ_RUNNING) begin
        for (int i = 0; i < MOTOR_COUNT; i++)
          w.push_back(bus_write(motor_bus_addr(i), REG_SPEED, spd[i]));
      end
    end else if (seq_mode == SEQ_SETTLING) begin
      if (settle_left != 16'd0) settle_left = settle_left - 16'd1;
      if (settle_left == 16'd0) enter_ramp();
    end else if (seq_mode == SEQ_RAMPING) begin
      level_out = (step_mod7 == 3'd0) ? ramp_level - cfg_model.jitter
                                      : ramp_level + cfg_model.jitter;
      for (int i = 0; i < MOTOR_COUNT; i++)
        if (cfg_model.motor_mask[i]) w.push_back(bus_write(motor_bus_addr(i), REG_SPEED, level_out));
      step_count = step_count + 9'd1;
      step_mod7 = (step_mod7 >= 3'd6) ? 3'd0 : step_mod7 + 3'd1;
      if (step_count >= {ramp_level, 1'b0}) begin
        step_count = '0;
        step_mod7  = '0;
        ramp_level = ramp_level + 8'd1;
        if (ramp_level == 8'd0 || ramp_level >= cfg_model.level_limit) seq_mode = SEQ_RUNNING;
      end
    end
    foreach (w[k]) begin
      w[k].last_write     = (k == w.size() - 1);
      w[k].motors_running = (seq_mode == SEQ_RUNNING);
      writes_due.push_back(w[k]);
    end
    return w.size();
  endfunction

  task automatic cfg_write(input cfg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      CFG_START_FLOOR:     cfg_model.start_floor     = val[7:0];
      CFG_LEVEL_FIRST:     cfg_model.level_first     = val[7:0];
      CFG_LEVEL_LIMIT:     cfg_model.level_limit     = val[7:0];
      CFG_JITTER:          cfg_model.jitter          = val[7:0];
      CFG_MOTOR_MASK:      cfg_model.motor_mask      = val[3:0];
      CFG_MOTOR_ADDRESSES: cfg_model.motor_addresses = val[27:0];
      CFG_SETTLE_TICKS:    cfg_model.settle_ticks    = val[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    cfg_write(CFG_START_FLOOR, 32'(c.start_floor));
    cfg_write(CFG_LEVEL_FIRST, 32'(c.level_first));
    cfg_write(CFG_LEVEL_LIMIT, 32'(c.level_limit));
    cfg_write(CFG_JITTER, 32'(c.jitter));
    cfg_write(CFG_MOTOR_MASK, 32'(c.motor_mask));
    cfg_write(CFG_MOTOR_ADDRESSES, 32'(c.motor_addresses));
    cfg_write(CFG_SETTLE_TICKS, 32'(c.settle_ticks));
  endtask

  task automatic offer(input logic act, input logic [3:0][7:0] spd, output int n);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    speed_0  <= spd[0];
    speed_1  <= spd[1];
    speed_2  <= spd[2];
    speed_3  <= spd[3];
    do @(posedge clk); while (in_stall !== 1'b0);
    n = predict_writes(act, spd);
    items_in++;
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed start/ramp/stop sequences, with some noise mixed in.
  task automatic offer_random(output bit counted);
    logic act;
    logic [3:0][7:0] spd;
    int pick;
    int n;
    act  = ACT_UPDATE;
    pick = $urandom_range(0, 9);
    for (int i = 0; i < MOTOR_COUNT; i++) spd[i] = 8'($urandom_range(0, 255));
    case (seq_mode)
      SEQ_STOPPED: begin
        if (pick < 7 && cfg_model.start_floor != 8'hFF) begin
          for (int i = 0; i < MOTOR_COUNT; i++)
            spd[i] = 8'($urandom_range(255, int'(cfg_model.start_floor) + 1));
        end else if (pick == 9) begin
          act = ACT_TICK;
        end
      end
      SEQ_SETTLING, SEQ_RAMPING: begin
        if (pick < 8) act = ACT_TICK;
      end
      default: begin
        if (pick < 5) begin
          for (int i = 0; i < MOTOR_COUNT; i++)
            if (spd[i] == 8'd0) spd[i] = 8'($urandom_range(1, 255));
        end else if (pick < 7) begin
          spd[$urandom_range(0, 3)] = 8'd0;
        end else if (pick == 7) begin
          act = ACT_TICK;
        end
      end
    endcase
    if (act == ACT_UPDATE) counted = (seq_mode == SEQ_STOPPED || seq_mode == SEQ_RUNNING);
    else counted = (seq_mode == SEQ_SETTLING || seq_mode == SEQ_RAMPING);
    offer(act, spd, n);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** motor_start_stop_sequencer_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    bus_write_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      writes_seen++;
      if (writes_due.size() == 0) begin
        $error("unexpected bus write: bus_address %0h device_register %0h write_data %0h",
               bus_address, device_register, write_data);
        err_count++;
      end else begin
        want = writes_due.pop_front();
        if (bus_address !== want.bus_address) begin
          $error("bus_address: expected %0h, got %0h", want.bus_address, bus_address);
          err_count++;
        end
        if (device_register !== want.device_register) begin
          $error("device_register: expected %0h, got %0h", want.device_register,
                 device_register);
          err_count++;
        end
        if (write_data !== want.write_data) begin
          $error("write_data: expected %0h, got %0h", want.write_data, write_data);
          err_count++;
        end
        if (last_write !== want.last_write) begin
          $error("last_write: expected %0b, got %0b", want.last_write, last_write);
          err_count++;
        end
        if (motors_running !== want.motors_running) begin
          $error("motors_running: expected %0b, got %0b", want.motors_running,
                 motors_running);
          err_count++;
        end
      end
    end
  end

  initial begin
    int wait_n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_n = stalls_on ? $urandom_range(0, 7) : 0;
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  initial begin
    int n;
    int done;
    bit counted;
    logic [1:0] cur_set;
    cfg_t dir_cfg[4];
    dir_row_t r;

    cfg_model = settings(8'd45, 8'd30, 8'd50, 8'd25, 4'hF, 28'd219870569, 16'd340);
    seq_mode    = SEQ_STOPPED;
    settle_left = '0;
    ramp_level  = '0;
    step_count  = '0;
    step_mod7   = '0;

    dir_cfg[0] = cfg_model;
    dir_cfg[1] = settings(8'd0, 8'd0, 8'd3, 8'd255, 4'hF, 28'd219870569, 16'd0);
    dir_cfg[2] = settings(8'd0, 8'd255, 8'd255, 8'd0, 4'h0, 28'hFFFFFFF, 16'd2);
    dir_cfg[3] = settings(8'd255, 8'd0, 8'd0, 8'd128, 4'hF, 28'd0, 16'hFFFF);

    // reset settings
    dir_steps.push_back(dir_row(2'd0, ACT_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b1, 7'h69, REG_SPEED, 8'd0));
    dir_steps.push_back(dir_row(2'd0, ACT_UPDATE, 8'd45, 8'd255, 8'd255, 8'd255,
                                1'b1, 7'h69, REG_SPEED, 8'd45));
    dir_steps.push_back(dir_row(2'd0, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd0, ACT_UPDATE, 8'd255, 8'd255, 8'd255, 8'd0,
                                1'b1, 7'h69, REG_SPEED, 8'd255));
    // start with no settle time, level zero skipped, full jitter wrap, then stop
    dir_steps.push_back(dir_row(2'd1, ACT_UPDATE, 8'd1, 8'd1, 8'd1, 8'd1,
                                1'b1, 7'h69, REG_ENABLE, 8'd0));
    dir_steps.push_back(dir_row(2'd1, ACT_UPDATE, 8'd9, 8'd9, 8'd9, 8'd9,
                                1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd1, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b1, 7'h69, REG_SPEED, 8'd2));
    dir_steps.push_back(dir_row(2'd1, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b1, 7'h69, REG_SPEED, 8'd0));
    for (int i = 0; i < 5; i++)
      dir_steps.push_back(dir_row(2'd1, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                  1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd1, ACT_UPDATE, 8'd200, 8'd200, 8'd200, 8'd200,
                                1'b1, 7'h69, REG_SPEED, 8'd200));
    dir_steps.push_back(dir_row(2'd1, ACT_UPDATE, 8'd10, 8'd20, 8'd30, 8'd0,
                                1'b1, 7'h68, REG_SPEED, 8'd0));
    dir_steps.push_back(dir_row(2'd1, ACT_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b1, 7'h69, REG_SPEED, 8'd0));
    // no motor selected, settle countdown, empty ramp
    dir_steps.push_back(dir_row(2'd2, ACT_UPDATE, 8'd1, 8'd2, 8'd3, 8'd4,
                                1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd2, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd2, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd2, ACT_UPDATE, 8'd7, 8'd7, 8'd7, 8'd7,
                                1'b1, 7'h7F, REG_SPEED, 8'd7));
    dir_steps.push_back(dir_row(2'd2, ACT_UPDATE, 8'd0, 8'd7, 8'd7, 8'd7,
                                1'b0, 7'h00, 8'h00, 8'd0));
    // start impossible at top threshold
    dir_steps.push_back(dir_row(2'd3, ACT_UPDATE, 8'd255, 8'd255, 8'd255, 8'd255,
                                1'b1, 7'h00, REG_SPEED, 8'd255));
    dir_steps.push_back(dir_row(2'd3, ACT_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                                1'b0, 7'h00, 8'h00, 8'd0));
    dir_steps.push_back(dir_row(2'd3, ACT_UPDATE, 8'd128, 8'd64, 8'd32, 8'd16,
                                1'b0, 7'h00, 8'h00, 8'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_set = 2'd0;
    foreach (dir_steps[i]) begin
      r = dir_steps[i];
      if (r.cfg_set != cur_set) begin
        drain_writes();
        apply_settings(dir_cfg[r.cfg_set]);
        cur_set = r.cfg_set;
      end
      offer(r.act, {r.s3, r.s2, r.s1, r.s0}, n);
      if (r.typed && n > 0) begin
        writes_due[writes_due.size() - n].bus_address     = r.t_addr;
        writes_due[writes_due.size() - n].device_register = r.t_reg;
        writes_due[writes_due.size() - n].write_data      = r.t_data;
      end
    end
    drain_writes();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(settings(8'($urandom_range(0, 220)), 8'($urandom_range(0, 4)),
                              8'($urandom_range(0, 6)), 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), 28'($urandom),
                              16'($urandom_range(0, 3))));
      gaps_on   = (p >= 2);
      stalls_on = (p >= 1);
      if (p == 1) hold_req = 1'b1;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        offer_random(counted);
        if (counted) done++;
      end
      drain_writes();
    end

    $display("Sent %0d transactions through %0d register settings; checked %0d bus writes.",
             items_in, RANDOM_PHASES + 4, writes_seen);
    $display("Motors started %0d times and stopped %0d times; %0d mismatches.",
             starts, stops, err_count);
    if (err_count == 0) begin
      $display("** motor_start_stop_sequencer_top: PASSED **");
    end else begin
      $display("** motor_start_stop_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
